/* rtl/fdr_pkg.sv */
`timescale 1ns / 1ps

package fdr_pkg;

    // default geometry
    localparam int COORD_WIDTH_DEF  = 12;
    localparam int RADIUS_WIDTH_DEF = 11;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // eight symmetric pixels per octant point
    localparam int PIX_PER_STEP = 8;
    localparam int IDX_W        = $clog2(PIX_PER_STEP);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIX_PER_STEP - 1);

endpackage

/* rtl/fdr_core.sv */
`timescale 1ns / 1ps

module fdr_core #(
    parameter int COORD_WIDTH  = fdr_pkg::COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = fdr_pkg::RADIUS_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_command,
    input  logic [COORD_WIDTH-1:0]    i_center_x,
    input  logic [COORD_WIDTH-1:0]    i_center_y,
    input  logic [RADIUS_WIDTH-1:0]   i_radius,
    input  logic [31:0]               i_color,
    // snapshot of one octant point toward the emitter
    output logic                      o_snap_valid,
    input  logic                      i_snap_take,
    output logic [COORD_WIDTH-1:0]    o_snap_cx,
    output logic [COORD_WIDTH-1:0]    o_snap_cy,
    output logic signed [RADIUS_WIDTH:0] o_snap_a,
    output logic signed [RADIUS_WIDTH:0] o_snap_b,
    output logic [31:0]               o_snap_color,
    output logic                      o_snap_done
);
    import fdr_pkg::*;

    localparam int OFS_W = RADIUS_WIDTH + 1;
    localparam int DEC_W = RADIUS_WIDTH + 3;

    logic                    r_active;
    logic [COORD_WIDTH-1:0]  r_cx;
    logic [COORD_WIDTH-1:0]  r_cy;
    logic [31:0]             r_color;
    logic [RADIUS_WIDTH-1:0] r_h;
    logic signed [OFS_W-1:0] r_a;
    logic signed [OFS_W-1:0] r_b;
    logic signed [DEC_W-1:0] r_k;
    logic                    r_snap_valid;

    logic                    in_acc;
    logic signed [DEC_W-1:0] a2;
    logic signed [DEC_W-1:0] b2;
    logic signed [DEC_W-1:0] hb2;
    logic signed [DEC_W-1:0] h_ext;
    logic signed [OFS_W-1:0] n_a;
    logic signed [OFS_W-1:0] n_b;
    logic signed [DEC_W-1:0] n_k;
    logic                    ring_end;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_snap_valid || i_snap_take;
    assign o_snap_valid = r_snap_valid;

    // three-way decision update for the current point
    always_comb begin
        a2    = DEC_W'(r_a) <<< 1;
        b2    = DEC_W'(r_b) <<< 1;
        h_ext = DEC_W'({1'b0, r_h});
        hb2   = (h_ext - DEC_W'(r_b)) <<< 1;
        n_a   = r_a;
        n_b   = r_b;
        if (r_k >= a2) begin
            n_k = r_k - a2 - DEC_W'(1);
            n_a = r_a + OFS_W'(1);
        end else if (r_k < hb2) begin
            n_k = r_k + b2 - DEC_W'(1);
            n_b = r_b - OFS_W'(1);
        end else begin
            n_k = r_k + b2 - a2 - DEC_W'(2);
            n_a = r_a + OFS_W'(1);
            n_b = r_b - OFS_W'(1);
        end
        ring_end = n_b < n_a;
    end

    // disc state and point snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_snap_valid <= 1'b0;
            r_cx         <= '0;
            r_cy         <= '0;
            r_color      <= '0;
            r_h          <= '0;
            r_a          <= '0;
            r_b          <= '0;
            r_k          <= '0;
        end else begin
            if (i_snap_take) begin
                r_snap_valid <= 1'b0;
            end
            if (in_acc) begin
                if (i_command == CMD_START) begin
                    r_cx     <= i_center_x;
                    r_cy     <= i_center_y;
                    r_color  <= i_color;
                    r_h      <= i_radius;
                    r_a      <= '0;
                    r_b      <= OFS_W'({1'b0, i_radius});
                    r_k      <= DEC_W'({1'b0, i_radius}) - DEC_W'(1);
                    r_active <= 1'b1;
                end else if (r_active) begin
                    r_snap_valid <= 1'b1;
                    o_snap_cx    <= r_cx;
                    o_snap_cy    <= r_cy;
                    o_snap_a     <= r_a;
                    o_snap_b     <= r_b;
                    o_snap_color <= r_color;
                    o_snap_done  <= ring_end && (r_h == '0);
                    r_k          <= n_k;
                    r_a          <= n_a;
                    r_b          <= n_b;
                    if (ring_end) begin
                        if (r_h == '0) begin
                            r_active <= 1'b0;
                        end else begin
                            r_h <= r_h - RADIUS_WIDTH'(1);
                            r_a <= '0;
                            r_b <= OFS_W'({1'b0, r_h}) - OFS_W'(1);
                            r_k <= DEC_W'({1'b0, r_h}) - DEC_W'(2);
                        end
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    // an active disc always has its point inside the octant
    a_octant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_a <= r_b))
        else $error("octant point left its octant");

    // a start transaction restarts the ring at the top of the octant
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command == CMD_START) |=> (r_active && r_a == '0))
        else $error("start did not restart the ring");

    // a step while idle never produces a snapshot
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command == CMD_STEP && !r_active && !r_snap_valid)
        |=> !r_snap_valid)
        else $error("idle step produced pixels");
`endif

endmodule

/* rtl/fdr_emit.sv */
`timescale 1ns / 1ps

module fdr_emit #(
    parameter int COORD_WIDTH  = fdr_pkg::COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = fdr_pkg::RADIUS_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_snap_valid,
    output logic                          o_snap_take,
    input  logic [COORD_WIDTH-1:0]        i_snap_cx,
    input  logic [COORD_WIDTH-1:0]        i_snap_cy,
    input  logic signed [RADIUS_WIDTH:0]  i_snap_a,
    input  logic signed [RADIUS_WIDTH:0]  i_snap_b,
    input  logic [31:0]                   i_snap_color,
    input  logic                          i_snap_done,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH+1:0] o_pixel_x,
    output logic signed [COORD_WIDTH+1:0] o_pixel_y,
    output logic [31:0]                   o_pixel_color,
    output logic                          o_last_of_step,
    output logic                          o_disc_done
);
    import fdr_pkg::*;

    localparam int PIX_W = COORD_WIDTH + 2;

    logic                          r_busy;
    logic [IDX_W-1:0]              r_idx;
    logic signed [PIX_W-1:0]       r_cx;
    logic signed [PIX_W-1:0]       r_cy;
    logic signed [PIX_W-1:0]       r_a;
    logic signed [PIX_W-1:0]       r_b;
    logic [31:0]                   r_color;
    logic                          r_done;

    logic                          out_load;
    logic                          step_end;
    logic signed [PIX_W-1:0]       u;
    logic signed [PIX_W-1:0]       v;
    logic signed [PIX_W-1:0]       px;
    logic signed [PIX_W-1:0]       py;

    assign out_load    = !o_out_valid || i_out_ready;
    assign step_end    = out_load && (r_idx == LAST_IDX);
    assign o_snap_take = i_snap_valid && (!r_busy || step_end);

    // symmetric pixel: bit 0 swaps offsets, bits 1 and 2 mirror x and y
    always_comb begin
        u  = r_idx[0] ? r_b : r_a;
        v  = r_idx[0] ? r_a : r_b;
        px = r_idx[1] ? (r_cx - u) : (r_cx + u);
        py = r_idx[2] ? (r_cy - v) : (r_cy + v);
    end

    // point buffer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                o_out_valid <= r_busy;
                if (r_busy) begin
                    o_pixel_x      <= px;
                    o_pixel_y      <= py;
                    o_pixel_color  <= r_color;
                    o_last_of_step <= (r_idx == LAST_IDX);
                    o_disc_done    <= (r_idx == LAST_IDX) && r_done;
                    r_idx          <= r_idx + IDX_W'(1);
                    if (r_idx == LAST_IDX) begin
                        r_busy <= 1'b0;
                    end
                end
            end
            if (o_snap_take) begin
                r_busy  <= 1'b1;
                r_idx   <= '0;
                r_cx    <= PIX_W'({1'b0, i_snap_cx});
                r_cy    <= PIX_W'({1'b0, i_snap_cy});
                r_a     <= PIX_W'(i_snap_a);
                r_b     <= PIX_W'(i_snap_b);
                r_color <= i_snap_color;
                r_done  <= i_snap_done;
            end
        end
    end

`ifndef SYNTHESIS
    // the disc ends only on the closing pixel of a step
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_disc_done) |-> o_last_of_step)
        else $error("disc done outside the last pixel");

    // the pixel counter runs only while a point is being emitted
    a_idx_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> r_busy)
        else $error("pixel counter moved while idle");

    // a taken snapshot starts at its first pixel
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_snap_take |=> (r_busy && r_idx == '0))
        else $error("snapshot not loaded");
`endif

endmodule

/* rtl/filled_disc_rasterizer_unit.sv */
`timescale 1ns / 1ps

// Filled disc rasterizer: Andres circles of radius r, r-1, ..., 0.
// Input channel (i_in_valid / o_in_ready): command 0 starts a disc and
// latches center, radius and color; command 1 advances one octant point.
// Output channel (o_out_valid / i_out_ready): pixel writes with color,
// a last-of-step flag on the eighth pixel and disc_done on the final one.
// A start transaction gives no pixels; a step while idle gives nothing.
// Each step gives eight pixel transactions, one per cycle while the receiver
// is ready. A step passes through the snapshot register and the emitter's
// point buffer before its first pixel leaves the output register; the single
// output register carries one pixel per cycle. The step logic runs ahead by
// one point, held in a snapshot register, so the next step is accepted while
// the current eight pixels drain.
// Reset (synchronous, active low) drops any disc in progress and empties
// the snapshot and output registers. When the receiver stalls, the current
// pixel holds; once the snapshot is also full, o_in_ready goes low.
module filled_disc_rasterizer_unit #(
    parameter int COORD_WIDTH  = fdr_pkg::COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = fdr_pkg::RADIUS_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [COORD_WIDTH-1:0]        i_center_x,
    input  logic [COORD_WIDTH-1:0]        i_center_y,
    input  logic [RADIUS_WIDTH-1:0]       i_radius,
    input  logic [31:0]                   i_color,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH+1:0] o_pixel_x,
    output logic signed [COORD_WIDTH+1:0] o_pixel_y,
    output logic [31:0]                   o_pixel_color,
    output logic                          o_last_of_step,
    output logic                          o_disc_done
);
    import fdr_pkg::*;

    logic                         snap_valid;
    logic                         snap_take;
    logic [COORD_WIDTH-1:0]       snap_cx;
    logic [COORD_WIDTH-1:0]       snap_cy;
    logic signed [RADIUS_WIDTH:0] snap_a;
    logic signed [RADIUS_WIDTH:0] snap_b;
    logic [31:0]                  snap_color;
    logic                         snap_done;

    // disc state and decision update
    fdr_core #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_color      (i_color),
        .o_snap_valid (snap_valid),
        .i_snap_take  (snap_take),
        .o_snap_cx    (snap_cx),
        .o_snap_cy    (snap_cy),
        .o_snap_a     (snap_a),
        .o_snap_b     (snap_b),
        .o_snap_color (snap_color),
        .o_snap_done  (snap_done)
    );

    // eight symmetric pixels per point
    fdr_emit #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_snap_valid   (snap_valid),
        .o_snap_take    (snap_take),
        .i_snap_cx      (snap_cx),
        .i_snap_cy      (snap_cy),
        .i_snap_a       (snap_a),
        .i_snap_b       (snap_b),
        .i_snap_color   (snap_color),
        .i_snap_done    (snap_done),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_last_of_step (o_last_of_step),
        .o_disc_done    (o_disc_done)
    );

endmodule

/* verif/fdr_pixel_checker.sv */
`timescale 1ns / 1ps

module fdr_pixel_checker #(
    parameter int COORD_WIDTH  = fdr_pkg::COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = fdr_pkg::RADIUS_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_command,
    input  logic [COORD_WIDTH-1:0]        i_center_x,
    input  logic [COORD_WIDTH-1:0]        i_center_y,
    input  logic [RADIUS_WIDTH-1:0]       i_radius,
    input  logic [31:0]                   i_color,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [COORD_WIDTH+1:0] i_pixel_x,
    input  logic signed [COORD_WIDTH+1:0] i_pixel_y,
    input  logic [31:0]                   i_pixel_color,
    input  logic                          i_last_of_step,
    input  logic                          i_disc_done,
    output int                            o_fail_count,
    output int                            o_pixels_pending
);
    import fdr_pkg::*;

    localparam int PIX_W       = COORD_WIDTH + 2;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [PIX_W-1:0] x;
        logic signed [PIX_W-1:0] y;
        logic [31:0]             color;
        logic                    last;
        logic                    done;
    } t_pixel;

    // predicted rasterizer state
    logic                          disc_active = 1'b0;
    logic        [COORD_WIDTH-1:0]  ctr_x       = '0;
    logic        [COORD_WIDTH-1:0]  ctr_y       = '0;
    logic        [31:0]             ink         = '0;
    logic        [RADIUS_WIDTH-1:0] ring_h      = '0;
    logic        [COORD_WIDTH-1:0]  pt_a        = '0;
    logic        [COORD_WIDTH-1:0]  pt_b        = '0;
    logic signed [PIX_W-1:0]        dec_k       = '0;

    // pixels still owed by the block, oldest first
    t_pixel expected_pixels [$];

    int fail_count     = 0;
    int pixels_pending = 0;

    assign o_fail_count     = fail_count;
    assign o_pixels_pending = pixels_pending;

    // first octant point of a ring of radius h
    function automatic void start_ring(input int h);
        ring_h = RADIUS_WIDTH'(h);
        pt_a   = '0;
        pt_b   = COORD_WIDTH'(h);
        dec_k  = PIX_W'(h - 1);
    endfunction

    always @(posedge i_clk) begin : monitor
        int     cx, cy, a, b, h, k, na, nb;
        int     dx [PIX_PER_STEP];
        int     dy [PIX_PER_STEP];
        logic   finished;
        t_pixel want;
        t_pixel pix;

        if (!i_rst_n) begin
            disc_active = 1'b0;
            ctr_x       = '0;
            ctr_y       = '0;
            ink         = '0;
            ring_h      = '0;
            pt_a        = '0;
            pt_b        = '0;
            dec_k       = '0;
            expected_pixels.delete();
        end else begin
            // pixel transaction against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b done=%b",
                                 $realtime, i_pixel_x, i_pixel_y, i_pixel_color,
                                 i_last_of_step, i_disc_done);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_x !== want.x || i_pixel_y !== want.y ||
                        i_pixel_color !== want.color || i_last_of_step !== want.last ||
                        i_disc_done !== want.done) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: pixel mismatch, expected x=%0d y=%0d color=%h %s",
                                     $realtime, want.x, want.y, want.color,
                                     $sformatf("last=%b done=%b", want.last, want.done));
                            $display("    got x=%0d y=%0d color=%h last=%b done=%b",
                                     i_pixel_x, i_pixel_y, i_pixel_color,
                                     i_last_of_step, i_disc_done);
                        end
                    end
                end
            end

            // command transaction
            if (i_in_valid && i_in_ready) begin
                if (i_command == CMD_START) begin
                    ctr_x       = i_center_x;
                    ctr_y       = i_center_y;
                    ink         = i_color;
                    start_ring(int'(i_radius));
                    disc_active = 1'b1;
                end else if (disc_active) begin
                    cx       = int'(ctr_x);
                    cy       = int'(ctr_y);
                    a        = int'(pt_a);
                    b        = int'(pt_b);
                    h        = int'(ring_h);
                    k        = int'(dec_k);
                    na       = a;
                    nb       = b;
                    finished = 1'b0;

                    // three-way decision update
                    if (k >= 2 * a) begin
                        k  = k - 2 * a - 1;
                        na = a + 1;
                    end else if (k < 2 * (h - b)) begin
                        k  = k + 2 * b - 1;
                        nb = b - 1;
                    end else begin
                        k  = k + 2 * (b - a - 1);
                        nb = b - 1;
                        na = a + 1;
                    end
                    pt_a  = COORD_WIDTH'(na);
                    pt_b  = COORD_WIDTH'(nb);
                    dec_k = PIX_W'(k);

                    // octant exhausted: next smaller ring, or the disc is complete
                    if (nb < na) begin
                        if (h == 0) begin
                            finished    = 1'b1;
                            disc_active = 1'b0;
                        end else begin
                            start_ring(h - 1);
                        end
                    end

                    // eight symmetric pixels of the point taken before the update
                    dx = '{a, b, -a, -b, a, b, -a, -b};
                    dy = '{b, a, b, a, -b, -a, -b, -a};
                    for (int i = 0; i < PIX_PER_STEP; i++) begin
                        pix.x     = PIX_W'(cx + dx[i]);
                        pix.y     = PIX_W'(cy + dy[i]);
                        pix.color = ink;
                        pix.last  = (i == PIX_PER_STEP - 1);
                        pix.done  = (i == PIX_PER_STEP - 1) && finished;
                        expected_pixels.push_back(pix);
                    end
                end
            end
        end
        pixels_pending = expected_pixels.size();
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import fdr_pkg::*;

    localparam int CW               = COORD_WIDTH_DEF;
    localparam int RW               = RADIUS_WIDTH_DEF;
    localparam int RESET_CYCLES     = 4;
    localparam int HOLD_OFF_CYCLES  = 200;
    localparam int SETTLE_CYCLES    = 16;
    localparam int CYCLE_LIMIT      = 300000;
    localparam int ITEMS_PER_PHASE  = 120;
    localparam int NUM_PHASES       = 4;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 command     = CMD_STEP;
    logic [CW-1:0]        center_x    = '0;
    logic [CW-1:0]        center_y    = '0;
    logic [RW-1:0]        radius      = '0;
    logic [31:0]          color       = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic signed [CW+1:0] pixel_x;
    logic signed [CW+1:0] pixel_y;
    logic [31:0]          pixel_color;
    logic                 last_of_step;
    logic                 disc_done;

    // idle and stall odds per phase, in percent
    int phase_idle  [NUM_PHASES] = '{0, 74, 0, 23};
    int phase_stall [NUM_PHASES] = '{0, 0, 74, 23};

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int cycle_count    = 0;
    int fail_count;
    int pixels_pending;

    filled_disc_rasterizer_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_command      (command),
        .i_center_x     (center_x),
        .i_center_y     (center_y),
        .i_radius       (radius),
        .i_color        (color),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_pixel_x      (pixel_x),
        .o_pixel_y      (pixel_y),
        .o_pixel_color  (pixel_color),
        .o_last_of_step (last_of_step),
        .o_disc_done    (disc_done)
    );

    fdr_pixel_checker #(
        .COORD_WIDTH  (CW),
        .RADIUS_WIDTH (RW)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_command        (command),
        .i_center_x       (center_x),
        .i_center_y       (center_y),
        .i_radius         (radius),
        .i_color          (color),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_pixel_x        (pixel_x),
        .i_pixel_y        (pixel_y),
        .i_pixel_color    (pixel_color),
        .i_last_of_step   (last_of_step),
        .i_disc_done      (disc_done),
        .o_fail_count     (fail_count),
        .o_pixels_pending (pixels_pending)
    );

    // clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // pixel receiver: random stalls, or a long hold-off on request
    initial begin : receiver
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one command transaction, with random idle cycles ahead of it
    task automatic send_item(input logic cmd, input logic [CW-1:0] cx,
                             input logic [CW-1:0] cy, input logic [RW-1:0] r,
                             input logic [31:0] ink);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        center_x <= cx;
        center_y <= cy;
        radius   <= r;
        color    <= ink;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // step commands carry junk in the unused fields
    task automatic send_steps(input int n);
        repeat (n) send_item(CMD_STEP, CW'($urandom()), CW'($urandom()),
                             RW'($urandom()), $urandom());
    endtask

    // stop offering and wait for every predicted pixel
    task automatic wait_until_drawn();
        in_valid <= 1'b0;
        do @(negedge clk); while (pixels_pending != 0);
    endtask

    initial begin : stimulus
        int sent;
        int pick;
        int r;
        int steps;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: idle step, zero radius, extreme centers and radii, restart
        send_steps(1);
        send_item(CMD_START, '0, '0, '0, '0);
        send_steps(2);
        send_item(CMD_START, '1, '1, '0, '1);
        send_steps(1);
        send_item(CMD_START, '0, '0, '1, 32'hA5A5_5A5A);
        send_steps(3);
        send_item(CMD_START, '1, '1, '1, 32'h5A5A_A5A5);
        send_steps(2);
        send_item(CMD_START, CW'(100), CW'(200), RW'(5), 32'h0000_00FF);
        send_steps(2);
        send_item(CMD_START, CW'(100), CW'(200), RW'(2), 32'h00FF_FF00);
        send_steps(7);
        wait_until_drawn();

        // receiver holds off while steps keep coming, so the input backs up
        send_item(CMD_START, CW'($urandom()), CW'($urandom()), RW'(1500), $urandom());
        hold_req = 1'b1;
        send_steps(12);
        wait_until_drawn();

        // random discs under each idling mix
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    // small disc, often run to completion and past it
                    r     = $urandom_range(10);
                    steps = $urandom_range(1, r * r / 2 + r + 3);
                    send_item(CMD_START, CW'($urandom()), CW'($urandom()), RW'(r),
                              $urandom());
                    send_steps(steps);
                    sent += steps + 1;
                end else if (pick < 92) begin
                    // large disc, cut short
                    steps = $urandom_range(1, 6);
                    send_item(CMD_START, CW'($urandom()), CW'($urandom()),
                              RW'($urandom_range(2047)), $urandom());
                    send_steps(steps);
                    sent += steps + 1;
                end else begin
                    // lone command with random fields
                    send_item(1'($urandom()), CW'($urandom()), CW'($urandom()),
                              RW'($urandom()), $urandom());
                    sent += 1;
                end
                if ($urandom_range(9) == 0) wait_until_drawn();
            end
            wait_until_drawn();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pixels_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
